FILE: hw/rtl/pwsl_pkg.sv
// ----------------------------------------------------------------------------
// pwsl_pkg
// Widths, register map, reset values and types of the PID controller with
// integrator windup guard and output slew limit.
// ----------------------------------------------------------------------------
package pwsl_pkg;

   localparam int SAMPLE_BITS    = 16;
   localparam int GAIN_FRAC_BITS = 8;

   localparam int GAIN_W  = 16;
   localparam int WIN_W   = 17;
   localparam int LIMIT_W = 20;
   localparam int SLEW_W  = 23;
   localparam int DRIVE_W = 24;
   localparam int SUM_W   = LIMIT_W + 1;

   localparam int ERR_W  = SAMPLE_BITS + 1;
   localparam int DERR_W = SAMPLE_BITS + 2;
   localparam int WCMP_W = ((ERR_W > WIN_W) ? ERR_W : WIN_W) + 1;
   localparam int SACC_W = ((SUM_W > ERR_W) ? SUM_W : ERR_W) + 1;

   localparam int P_W   = GAIN_W + ERR_W;
   localparam int I_W   = GAIN_W + SUM_W;
   localparam int D_W   = GAIN_W + DERR_W;
   localparam int ACC_W = ((I_W > D_W) ? I_W : D_W) + 2;
   localparam int U_W   = ACC_W - GAIN_FRAC_BITS;
   localparam int CLP_W = ((U_W > DRIVE_W) ? U_W : DRIVE_W) + 2;

   localparam int DATA_W = 32;
   localparam int NUM_REGS = 8;
   localparam int IDX_W = $clog2(NUM_REGS);
   localparam int ADDR_W = IDX_W + 2;

   localparam logic [IDX_W-1:0] REG_KP        = IDX_W'(0);
   localparam logic [IDX_W-1:0] REG_KI        = IDX_W'(1);
   localparam logic [IDX_W-1:0] REG_KD        = IDX_W'(2);
   localparam logic [IDX_W-1:0] REG_WINDOW    = IDX_W'(3);
   localparam logic [IDX_W-1:0] REG_SUM_LIMIT = IDX_W'(4);
   localparam logic [IDX_W-1:0] REG_SLEW_STEP = IDX_W'(5);
   localparam logic [IDX_W-1:0] REG_OUT_MAX   = IDX_W'(6);
   localparam logic [IDX_W-1:0] REG_OUT_MIN   = IDX_W'(7);

   typedef struct packed {
      logic signed [GAIN_W-1:0]  kp;
      logic signed [GAIN_W-1:0]  ki;
      logic signed [GAIN_W-1:0]  kd;
      logic        [WIN_W-1:0]   integrate_window;
      logic        [LIMIT_W-1:0] sum_limit;
      logic        [SLEW_W-1:0]  slew_step;
      logic signed [DRIVE_W-1:0] out_max;
      logic signed [DRIVE_W-1:0] out_min;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      kp:               GAIN_W'(1) << GAIN_FRAC_BITS,
      ki:               '0,
      kd:               '0,
      integrate_window: WIN_W'(1) << (WIN_W - 1),
      sum_limit:        {LIMIT_W{1'b1}},
      slew_step:        {SLEW_W{1'b1}},
      out_max:          {1'b0, {(DRIVE_W-1){1'b1}}},
      out_min:          {1'b1, {(DRIVE_W-1){1'b0}}}
   };

endpackage

FILE: hw/rtl/pwsl_if.sv
// ----------------------------------------------------------------------------
// pwsl_if
// Valid/ready channels: sample word in, drive word out.
// ----------------------------------------------------------------------------
interface pwsl_req_if;
   logic                                     valid;
   logic                                     ready;
   logic signed [pwsl_pkg::SAMPLE_BITS-1:0]  target;
   logic signed [pwsl_pkg::SAMPLE_BITS-1:0]  measured;

   modport source (output valid, output target, output measured, input ready);
   modport sink   (input valid, input target, input measured, output ready);
endinterface

interface pwsl_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [pwsl_pkg::DRIVE_W-1:0]  drive;

   modport source (output valid, output drive, input ready);
   modport sink   (input valid, input drive, output ready);
endinterface

FILE: hw/rtl/pid_windup_slew_limited_unit.sv
// ----------------------------------------------------------------------------
// pid_windup_slew_limited_unit
// Fixed-point positional PID with windowed integration, integrator clamp,
// output slew limit and output clamp; APB-style register port.
// ----------------------------------------------------------------------------
// A word accepted into stage 0 moves through stages 1, 2 and 3 to the output register.
// Throughput: one word per cycle while rsp.ready holds; integrator and last-drive
// loops each close in one stage, the three gain multiplies sit in their own stage.
// Stages with no word take a new one even while a result waits downstream.
// Reset: synchronous; clears the pipeline, integrator, last error and last
// drive, and loads the register defaults.
module pid_windup_slew_limited_unit (
   input  logic                                clock,
   input  logic                                reset,
   pwsl_req_if.sink                            req,
   pwsl_rsp_if.source                          rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pwsl_pkg::ADDR_W-1:0]         paddr,
   input  logic [pwsl_pkg::DATA_W-1:0]         pwdata,
   output logic [pwsl_pkg::DATA_W-1:0]         prdata,
   output logic                                pready
);

   localparam int SB      = pwsl_pkg::SAMPLE_BITS;
   localparam int ERR_W   = pwsl_pkg::ERR_W;
   localparam int DERR_W  = pwsl_pkg::DERR_W;
   localparam int SUM_W   = pwsl_pkg::SUM_W;
   localparam int WCMP_W  = pwsl_pkg::WCMP_W;
   localparam int SACC_W  = pwsl_pkg::SACC_W;
   localparam int P_W     = pwsl_pkg::P_W;
   localparam int I_W     = pwsl_pkg::I_W;
   localparam int D_W     = pwsl_pkg::D_W;
   localparam int ACC_W   = pwsl_pkg::ACC_W;
   localparam int U_W     = pwsl_pkg::U_W;
   localparam int CLP_W   = pwsl_pkg::CLP_W;
   localparam int DRIVE_W = pwsl_pkg::DRIVE_W;
   localparam int DATA_W  = pwsl_pkg::DATA_W;
   localparam int IDX_W   = pwsl_pkg::IDX_W;
   localparam int ADDR_W  = pwsl_pkg::ADDR_W;

   localparam logic signed [SUM_W-1:0] SUM_MOST_NEG = {1'b1, {(SUM_W-1){1'b0}}};

   // ---------------- register port ----------------
   pwsl_pkg::cfg_type   cfg_ff, cfg_in;
   logic                cfg_wr;
   logic [IDX_W-1:0]    cfg_idx;

   assign pready  = 1'b1;
   assign cfg_wr  = psel && penable && pwrite && pready;
   assign cfg_idx = paddr[ADDR_W-1:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         case (cfg_idx)
            pwsl_pkg::REG_KP:        cfg_in.kp = pwdata[pwsl_pkg::GAIN_W-1:0];
            pwsl_pkg::REG_KI:        cfg_in.ki = pwdata[pwsl_pkg::GAIN_W-1:0];
            pwsl_pkg::REG_KD:        cfg_in.kd = pwdata[pwsl_pkg::GAIN_W-1:0];
            pwsl_pkg::REG_WINDOW:    cfg_in.integrate_window = pwdata[pwsl_pkg::WIN_W-1:0];
            pwsl_pkg::REG_SUM_LIMIT: cfg_in.sum_limit = pwdata[pwsl_pkg::LIMIT_W-1:0];
            pwsl_pkg::REG_SLEW_STEP: cfg_in.slew_step = pwdata[pwsl_pkg::SLEW_W-1:0];
            pwsl_pkg::REG_OUT_MAX:   cfg_in.out_max = pwdata[DRIVE_W-1:0];
            pwsl_pkg::REG_OUT_MIN:   cfg_in.out_min = pwdata[DRIVE_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (cfg_idx)
         pwsl_pkg::REG_KP:        prdata = DATA_W'({cfg_ff.kp});
         pwsl_pkg::REG_KI:        prdata = DATA_W'({cfg_ff.ki});
         pwsl_pkg::REG_KD:        prdata = DATA_W'({cfg_ff.kd});
         pwsl_pkg::REG_WINDOW:    prdata = DATA_W'(cfg_ff.integrate_window);
         pwsl_pkg::REG_SUM_LIMIT: prdata = DATA_W'(cfg_ff.sum_limit);
         pwsl_pkg::REG_SLEW_STEP: prdata = DATA_W'(cfg_ff.slew_step);
         pwsl_pkg::REG_OUT_MAX:   prdata = DATA_W'({cfg_ff.out_max});
         pwsl_pkg::REG_OUT_MIN:   prdata = DATA_W'({cfg_ff.out_min});
         default:                 prdata = '0;
      endcase
   end

   // ---------------- pipeline flow ----------------
   logic s0_v_ff, s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic free0, free1, free2, free3, free4;

   assign free4 = !out_v_ff || rsp.ready;
   assign free3 = !s3_v_ff || free4;
   assign free2 = !s2_v_ff || free3;
   assign free1 = !s1_v_ff || free2;
   assign free0 = !s0_v_ff || free1;

   assign req.ready = free0;

   // stage 0: input word
   logic signed [SB-1:0] s0_target_ff, s0_measured_ff;

   // stage 1: error, integrator, error delta
   logic signed [ERR_W-1:0]  e_in, s1_e_ff, prev_err_ff;
   logic signed [DERR_W-1:0] de_in, s1_de_ff;
   logic signed [SUM_W-1:0]  sum_in, err_sum_ff, s1_sum_ff;
   logic signed [WCMP_W-1:0] e_w, win_w;
   logic signed [SACC_W-1:0] sum_raw, lim_w;
   logic                     in_window;

   assign win_w = WCMP_W'(cfg_ff.integrate_window);
   assign lim_w = SACC_W'(cfg_ff.sum_limit);

   always_comb begin
      e_in      = ERR_W'(s0_target_ff) - ERR_W'(s0_measured_ff);
      e_w       = WCMP_W'(e_in);
      in_window = (e_w < win_w) && (e_w > -win_w);
      sum_raw   = SACC_W'(err_sum_ff) + (in_window ? SACC_W'(e_in) : SACC_W'(0));
      if (sum_raw > lim_w) begin
         sum_in = SUM_W'(lim_w);
      end else if (sum_raw < -lim_w) begin
         sum_in = SUM_W'(-lim_w);
      end else begin
         sum_in = SUM_W'(sum_raw);
      end
      de_in = DERR_W'(e_in) - DERR_W'(prev_err_ff);
   end

   // stage 2: gain products
   logic signed [P_W-1:0] p_in, s2_p_ff;
   logic signed [I_W-1:0] i_in, s2_i_ff;
   logic signed [D_W-1:0] d_in, s2_d_ff;

   assign p_in = cfg_ff.kp * s1_e_ff;
   assign i_in = cfg_ff.ki * s1_sum_ff;
   assign d_in = cfg_ff.kd * s1_de_ff;

   // stage 3: sum and scale
   logic signed [ACC_W-1:0] acc;
   logic signed [U_W-1:0]   u_in, s3_u_ff;

   assign acc  = ACC_W'(s2_p_ff) + ACC_W'(s2_i_ff) + ACC_W'(s2_d_ff);
   assign u_in = U_W'(acc >>> pwsl_pkg::GAIN_FRAC_BITS);

   // stage 4: slew limit against the last drive, then clamp to out_min..out_max
   logic signed [DRIVE_W-1:0] drive_in, drive_ff;
   logic signed [CLP_W-1:0]   prev_c, u_c, step_c, diff_c, slew_c;

   always_comb begin
      prev_c = CLP_W'(drive_ff);
      u_c    = CLP_W'(s3_u_ff);
      step_c = CLP_W'(cfg_ff.slew_step);
      diff_c = u_c - prev_c;
      if (diff_c > step_c) begin
         slew_c = prev_c + step_c;
      end else if (diff_c < -step_c) begin
         slew_c = prev_c - step_c;
      end else begin
         slew_c = u_c;
      end
      if (slew_c > CLP_W'(cfg_ff.out_max)) begin
         drive_in = cfg_ff.out_max;
      end else if (slew_c < CLP_W'(cfg_ff.out_min)) begin
         drive_in = cfg_ff.out_min;
      end else begin
         drive_in = DRIVE_W'(slew_c);
      end
   end

   assign rsp.valid = out_v_ff;
   assign rsp.drive = drive_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff      <= pwsl_pkg::CFG_RESET;
         s0_v_ff     <= 1'b0;
         s1_v_ff     <= 1'b0;
         s2_v_ff     <= 1'b0;
         s3_v_ff     <= 1'b0;
         out_v_ff    <= 1'b0;
         prev_err_ff <= '0;
         err_sum_ff  <= '0;
         drive_ff    <= '0;
      end else begin
         cfg_ff <= cfg_in;
         if (free0) s0_v_ff <= req.valid;
         if (free1) s1_v_ff <= s0_v_ff;
         if (free2) s2_v_ff <= s1_v_ff;
         if (free3) s3_v_ff <= s2_v_ff;
         if (free4) out_v_ff <= s3_v_ff;
         if (free1 && s0_v_ff) begin
            prev_err_ff <= e_in;
            err_sum_ff  <= sum_in;
         end
         if (free4 && s3_v_ff) begin
            drive_ff <= drive_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (free0 && req.valid) begin
         s0_target_ff   <= req.target;
         s0_measured_ff <= req.measured;
      end
      if (free1 && s0_v_ff) begin
         s1_e_ff   <= e_in;
         s1_sum_ff <= sum_in;
         s1_de_ff  <= de_in;
      end
      if (free2 && s1_v_ff) begin
         s2_p_ff <= p_in;
         s2_i_ff <= i_in;
         s2_d_ff <= d_in;
      end
      if (free3 && s2_v_ff) begin
         s3_u_ff <= u_in;
      end
   end

   // ---------------- assertions ----------------
   a_accept_fills_s0 : assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> s0_v_ff)
      else $error("accepted word did not reach input stage");

   a_s3_holds : assert property (@(posedge clock) disable iff (reset)
      (s3_v_ff && !free4) |=> (s3_v_ff && $stable(s3_u_ff)))
      else $error("stalled stage 3 word lost or changed");

   a_sum_clamped : assert property (@(posedge clock) disable iff (reset)
      err_sum_ff != SUM_MOST_NEG)
      else $error("integrator escaped its clamp");

endmodule
